// ===== design/aed_pkg.sv =====
// Shared types and constants for the escape decoder: transaction payloads,
// the queued result entry and the depth of the result queue. No dependencies.
package aed_pkg;

    localparam int QUEUE_DEPTH = 2;
    localparam int PTR_W       = $clog2(QUEUE_DEPTH);
    localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);

    typedef struct packed {
        logic [7:0] in_byte;
        logic       is_final;
    } aed_in_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       run_last;
        logic       string_done;
    } aed_out_t;

    // All results of one input transaction: one or two decoded bytes.
    typedef struct packed {
        logic [7:0] first_byte;
        logic [7:0] second_byte;
        logic       two;
        logic       fin;
    } aed_entry_t;

endpackage

// ===== design/ansi_escape_decoder_unit.sv =====
// Top level of the ANSI-C string escape decoder: decoder core and result
// queue. Depends on aed_pkg, aed_decode and aed_queue.
//
//  Channel   Direction  Payload      Handshake
//  s_        in         aed_in_t     s_valid / s_ready
//  m_        out        aed_out_t    m_valid / m_ready
//
// One input transaction is taken per cycle while the result queue has a free
// entry; its results are in the queue the next cycle. A result channel drains
// one byte per cycle while m_ready is high, so a run of items that each give
// two bytes (an unknown escape, or an octal escape cut short) is drain-bound.
// Reset (aresetn low, synchronous) empties the queue, holds s_ready low and
// returns the decoder to normal mode. A stall on m_ready holds the head byte;
// outside reset, s_ready falls only when both queue entries are occupied.
module ansi_escape_decoder_unit (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  aed_pkg::aed_in_t  s_data,
    output logic              m_valid,
    input  logic              m_ready,
    output aed_pkg::aed_out_t m_data
);
    import aed_pkg::*;

    logic       accept;
    logic       push;
    logic       full;
    aed_entry_t entry;

    // advance the decoder on every accepted transaction; take nothing in reset
    assign s_ready = aresetn && !full;
    assign accept  = s_valid && s_ready;

    aed_decode u_decode (
        .aclk    (aclk),
        .aresetn (aresetn),
        .accept  (accept),
        .in_data (s_data),
        .push    (push),
        .entry   (entry)
    );

    // hold the results of each transaction until the consumer takes them
    aed_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (push),
        .push_entry (entry),
        .full       (full),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_data     (m_data)
    );

endmodule

// ===== design/aed_decode.sv =====
// Escape decoder core: holds the escape state and turns one input byte into
// zero, one or two result bytes in a single pass. Depends on aed_pkg.
module aed_decode (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                accept,
    input  aed_pkg::aed_in_t    in_data,
    output logic                push,
    output aed_pkg::aed_entry_t entry
);
    import aed_pkg::*;

    typedef enum logic [1:0] {
        MODE_NORMAL = 2'd0,
        MODE_ESC    = 2'd1,
        MODE_OCTAL  = 2'd2
    } mode_t;

    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_SQUOTE = 8'h27;
    localparam logic [7:0] CH_DQUOTE = 8'h22;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_SEVEN  = 8'h37;
    localparam logic [1:0] OCT_MAX   = 2'd3;

    mode_t      mode_reg, mode_next;
    logic [7:0] oval_reg, oval_next;
    logic [1:0] odig_reg, odig_next;

    logic [7:0] b;
    logic       fin;
    logic       is_oct;
    logic [7:0] oval_acc;
    logic [1:0] odig_acc;
    logic [1:0] cnt;
    logic [7:0] r0, r1;

    assign b        = in_data.in_byte;
    assign fin      = in_data.is_final;
    assign is_oct   = (b inside {[CH_ZERO:CH_SEVEN]}) && (odig_reg < OCT_MAX);
    assign oval_acc = {oval_reg[4:0], b[2:0]};
    assign odig_acc = odig_reg + 2'd1;

    always_comb begin
        mode_next = MODE_NORMAL;
        oval_next = oval_reg;
        odig_next = odig_reg;
        cnt       = 2'd0;
        r0        = b;
        r1        = b;
        case (mode_reg)
            MODE_ESC: begin
                cnt = 2'd1;
                case (b)
                    8'h6E:     r0 = 8'h0A;
                    8'h74:     r0 = 8'h09;
                    8'h72:     r0 = 8'h0D;
                    8'h62:     r0 = 8'h08;
                    8'h61:     r0 = 8'h07;
                    8'h66:     r0 = 8'h0C;
                    8'h76:     r0 = 8'h0B;
                    CH_BSLASH: r0 = CH_BSLASH;
                    CH_SQUOTE: r0 = CH_SQUOTE;
                    CH_DQUOTE: r0 = CH_DQUOTE;
                    CH_ZERO: begin
                        mode_next = MODE_OCTAL;
                        oval_next = 8'd0;
                        odig_next = 2'd0;
                        r0        = 8'd0;
                        cnt       = fin ? 2'd1 : 2'd0;
                    end
                    default: begin
                        r0  = CH_BSLASH;
                        cnt = 2'd2;
                    end
                endcase
            end
            MODE_OCTAL: begin
                if (is_oct) begin
                    oval_next = oval_acc;
                    odig_next = odig_acc;
                    r0        = oval_acc;
                    if (odig_acc >= OCT_MAX || fin) begin
                        cnt = 2'd1;
                    end else begin
                        mode_next = MODE_OCTAL;
                    end
                end else begin
                    // flush the pending value, then treat the byte as normal
                    r0 = oval_reg;
                    if (b == CH_BSLASH && !fin) begin
                        mode_next = MODE_ESC;
                        cnt       = 2'd1;
                    end else begin
                        cnt = 2'd2;
                    end
                end
            end
            default: begin
                if (b == CH_BSLASH && !fin) begin
                    mode_next = MODE_ESC;
                end else begin
                    cnt = 2'd1;
                end
            end
        endcase
        if (mode_next != MODE_OCTAL) begin
            oval_next = 8'd0;
            odig_next = 2'd0;
        end
        if (fin) begin
            mode_next = MODE_NORMAL;
            oval_next = 8'd0;
            odig_next = 2'd0;
        end
    end

    assign push              = accept && (cnt != 2'd0);
    assign entry.first_byte  = r0;
    assign entry.second_byte = r1;
    assign entry.two         = (cnt == 2'd2);
    assign entry.fin         = fin;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg <= MODE_NORMAL;
            oval_reg <= 8'd0;
            odig_reg <= 2'd0;
        end else if (accept) begin
            mode_reg <= mode_next;
            oval_reg <= oval_next;
            odig_reg <= odig_next;
        end
    end

endmodule

// ===== design/aed_queue.sv =====
// Result queue: holds decoded entries of one or two bytes and hands them out
// one byte per transaction on the result channel. Depends on aed_pkg.
module aed_queue (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                push,
    input  aed_pkg::aed_entry_t push_entry,
    output logic                full,
    output logic                m_valid,
    input  logic                m_ready,
    output aed_pkg::aed_out_t   m_data
);
    import aed_pkg::*;

    aed_entry_t       slot_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;
    logic             sub_reg;
    aed_entry_t       head;
    logic             take;
    logic             pop;

    assign head    = slot_reg[rd_ptr_reg];
    assign full    = (count_reg == CNT_W'(QUEUE_DEPTH));
    assign m_valid = (count_reg != '0);
    assign take    = m_valid && m_ready;
    // drop the entry once its last byte has gone
    assign pop     = take && (!head.two || sub_reg);

    always_comb begin
        if (head.two && !sub_reg) begin
            m_data.out_byte    = head.first_byte;
            m_data.run_last    = 1'b0;
            m_data.string_done = 1'b0;
        end else begin
            m_data.out_byte    = head.two ? head.second_byte : head.first_byte;
            m_data.run_last    = 1'b1;
            m_data.string_done = head.fin;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= push_entry;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
            sub_reg    <= 1'b0;
        end else begin
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + PTR_W'(1);
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + PTR_W'(1);
                sub_reg    <= 1'b0;
            end else if (take) begin
                sub_reg <= 1'b1;
            end
            if (push && !pop) begin
                count_reg <= count_reg + CNT_W'(1);
            end else if (pop && !push) begin
                count_reg <= count_reg - CNT_W'(1);
            end
        end
    end

endmodule
